// ===== sv/assert_macros.svh =====
// Assertion helpers for the scheduler unit; clocked on clk, off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  `ASSERT_CLK(label, !(cond), msg)

`endif

// ===== sv/pptsch_pkg.sv =====
package pptsch_pkg;

  localparam int SLOTS_DEF      = 32;
  localparam int TIME_WIDTH_DEF = 32;

  // operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_ADD_OK   = 2'd0,
    ST_ADD_FULL = 2'd1,
    ST_RAN      = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  typedef struct packed {
    logic        op;
    logic [7:0]  job_id;
    logic [15:0] burst_time;
    logic [7:0]  priority_level;
  } sched_in_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  run_id;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] response;
    logic [31:0] tick_now;
  } sched_out_t;

  // per-slot bookkeeping kept in the meta RAM
  typedef struct packed {
    logic [7:0]  job;
    logic [15:0] remaining;
    logic [7:0]  prio;
    logic [15:0] seq;
    logic        started;
  } slot_meta_t;

  // ordering key: higher prio first, then larger age
  typedef struct packed {
    logic [7:0]  prio;
    logic [15:0] age;
  } pick_key_t;

endpackage

// ===== sv/pptsch_ram.sv =====
module pptsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/pptsch_pick.sv =====
module pptsch_pick import pptsch_pkg::*; #(
  parameter int IDX_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             clear,
  input  logic             cand_en,
  input  logic [IDX_W-1:0] cand_idx,
  input  pick_key_t        cand_key,
  output logic             found,
  output logic [IDX_W-1:0] best_idx
);

  pick_key_t best_key;
  logic      win;

  // strict compare: on a full tie the earlier (lower) slot stays
  always_comb begin
    win = !found ||
          (cand_key.prio > best_key.prio) ||
          ((cand_key.prio == best_key.prio) && (cand_key.age > best_key.age));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (clear) begin
      found <= 1'b0;
    end else if (cand_en && win) begin
      found    <= 1'b1;
      best_idx <= cand_idx;
      best_key <= cand_key;
    end
  end

endmodule

// ===== sv/preemptive_priority_tick_scheduler_unit.sv =====
// Add transaction: walks the valid bits for the lowest free slot (every slot when the table is full);
// a tick scans every slot through the slot RAM, then fetches and updates the winner (no update when idle).
// The next transaction can be taken in the cycle after the result enters the output register,
// so each add or tick finishes before the next one is accepted.
// Only one transaction is in flight; a finished result waits in the output register.
// Reset (rst, synchronous) empties all slots and clears counters; slot RAMs keep contents.
module preemptive_priority_tick_scheduler_unit import pptsch_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  sched_in_t  in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output sched_out_t out_data
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int META_W = $bits(slot_meta_t);
  localparam int TIME_W2 = 2 * TIME_WIDTH;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Sequencer:
  //  S_FIND   - add: walk the valid bits for the lowest free slot
  //  S_SCAN   - tick: stream every slot out of the RAM into the pick unit
  //  S_DRAIN  - last RAM read lands in the pick unit
  //  S_FETCH  - read the winner back (or report idle)
  //  S_UPDATE - decrement, stamp first run, write back, build result
  //  S_DONE   - hand result to the output register once it is free
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_SCAN,
    S_DRAIN,
    S_FETCH,
    S_UPDATE,
    S_DONE
  } state_t;

  state_t                state;
  sched_in_t             cur;
  sched_out_t            res;
  logic [IDX_W-1:0]      scan_idx;
  logic                  rd_vld;
  logic [IDX_W-1:0]      rd_idx;
  logic [SLOTS-1:0]      slot_valid;
  logic [15:0]           add_counter;
  logic [TIME_WIDTH-1:0] tick_counter;

  // RAM ports
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  slot_meta_t            meta_wd;
  slot_meta_t            meta_rd;
  logic [META_W-1:0]     meta_rd_raw;
  logic [TIME_W2-1:0]    time_wd;
  logic [TIME_W2-1:0]    time_rd;

  // pick unit
  logic                  pick_found;
  logic [IDX_W-1:0]      pick_idx;
  pick_key_t             cand_key;

  // update datapath
  logic [TIME_WIDTH-1:0] arrival;
  logic [TIME_WIDTH-1:0] first_run;
  logic [TIME_WIDTH-1:0] turn_t;
  logic [TIME_WIDTH-1:0] resp_t;
  logic [15:0]           rem_dec;
  logic                  fin;
  logic [15:0]           burst_eff;

  assign meta_rd  = slot_meta_t'(meta_rd_raw);
  assign in_ready = (state == S_IDLE);

  pptsch_ram #(
    .WIDTH (META_W),
    .DEPTH (SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (META_W'(meta_wd)),
    .raddr (ram_raddr),
    .rdata (meta_rd_raw)
  );

  // {arrival, first_run}
  pptsch_ram #(
    .WIDTH (TIME_W2),
    .DEPTH (SLOTS)
  ) u_time_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (time_wd),
    .raddr (ram_raddr),
    .rdata (time_rd)
  );

  // age wraps at 16 bits, as the add counter does
  assign cand_key = '{prio: meta_rd.prio, age: add_counter - meta_rd.seq};

  pptsch_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst      (rst),
    .clear    (state == S_IDLE),
    .cand_en  (rd_vld),
    .cand_idx (rd_idx),
    .cand_key (cand_key),
    .found    (pick_found),
    .best_idx (pick_idx)
  );

  // Winner update: one decrement, two time differences.
  always_comb begin
    arrival   = time_rd[TIME_W2-1:TIME_WIDTH];
    first_run = meta_rd.started ? time_rd[TIME_WIDTH-1:0] : tick_counter;
    rem_dec   = meta_rd.remaining - 16'd1;
    fin       = (rem_dec == 16'd0);
    turn_t    = tick_counter + TIME_WIDTH'(1) - arrival;
    resp_t    = first_run - arrival;
    // zero burst is served as one tick
    burst_eff = (cur.burst_time == 16'd0) ? 16'd1 : cur.burst_time;
  end

  // RAM address and write muxing
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = scan_idx;
    ram_raddr = scan_idx;
    meta_wd   = '{job: cur.job_id, remaining: burst_eff, prio: cur.priority_level,
                  seq: add_counter, started: 1'b0};
    time_wd   = {tick_counter, tick_counter};
    case (state)
      S_FIND: begin
        ram_we = !slot_valid[scan_idx];
      end
      S_FETCH: begin
        ram_raddr = pick_idx;
      end
      S_UPDATE: begin
        ram_we    = 1'b1;
        ram_waddr = pick_idx;
        ram_raddr = pick_idx;
        meta_wd   = '{job: meta_rd.job, remaining: rem_dec, prio: meta_rd.prio,
                      seq: meta_rd.seq, started: 1'b1};
        time_wd   = {arrival, first_run};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      rd_vld       <= 1'b0;
      slot_valid   <= '0;
      add_counter  <= 16'd0;
      tick_counter <= '0;
    end else begin
      rd_vld <= (state == S_SCAN) && slot_valid[scan_idx];
      rd_idx <= scan_idx;
      // in S_DONE the hand-over below decides the output valid on its own
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur      <= in_data;
            scan_idx <= '0;
            res      <= '{status: ST_ADD_OK, run_id: 8'd0, finished: 1'b0,
                          turnaround: 32'd0, response: 32'd0,
                          tick_now: 32'(tick_counter)};
            state    <= (in_data.op == OP_TICK) ? S_SCAN : S_FIND;
          end
        end
        S_FIND: begin
          if (!slot_valid[scan_idx]) begin
            slot_valid[scan_idx] <= 1'b1;
            add_counter          <= add_counter + 16'd1;
            res.status           <= ST_ADD_OK;
            state                <= S_DONE;
          end else if (scan_idx == LAST_IDX) begin
            res.status <= ST_ADD_FULL;
            state      <= S_DONE;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_SCAN: begin
          if (scan_idx == LAST_IDX) begin
            state <= S_DRAIN;
          end else begin
            scan_idx <= scan_idx + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state <= S_FETCH;
        end
        S_FETCH: begin
          if (pick_found) begin
            state <= S_UPDATE;
          end else begin
            res.status   <= ST_IDLE;
            tick_counter <= tick_counter + TIME_WIDTH'(1);
            state        <= S_DONE;
          end
        end
        S_UPDATE: begin
          res.status     <= ST_RAN;
          res.run_id     <= meta_rd.job;
          res.finished   <= fin;
          res.turnaround <= fin ? 32'(turn_t) : 32'd0;
          res.response   <= fin ? 32'(resp_t) : 32'd0;
          if (fin) begin
            slot_valid[pick_idx] <= 1'b0;
          end
          tick_counter <= tick_counter + TIME_WIDTH'(1);
          state        <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  // A full table is reported only when every slot really is occupied.
  `ASSERT_CLK(a_full_only_when_full, (state == S_FIND && scan_idx == LAST_IDX && slot_valid[LAST_IDX]) |-> (&slot_valid), "add rejected with a free slot")
  // Slot RAMs are written only while placing a job or updating the winner.
  `ASSERT_CLK(a_ram_write_phase, ram_we |-> (state == S_FIND || state == S_UPDATE), "slot RAM written outside add or update")
  // A finished job is only ever reported on a run result.
  `ASSERT_NEVER(a_finish_needs_run, out_valid && out_data.finished && out_data.status != ST_RAN, "finished flag on a non-run result")
  // Reaching the update step means the scan did find a runnable job.
  `ASSERT_CLK(a_update_has_winner, (state == S_UPDATE) |-> (pick_found && slot_valid[pick_idx]), "update without a valid winner")

endmodule
